/* design/cdm_pkg.sv */
// constants, types and register codes for the compensation delay mixer
// no dependencies; compiled first

package cdm_pkg;

  localparam int Channels   = 4;
  localparam int DepthLog2  = 14;
  localparam int SampleBits = 24;

  localparam int ChBits      = 2;
  localparam int DelayBits   = 14;
  localparam int GainBits    = 17;
  localparam int DelayRegs   = 4;
  localparam int DelayIdxBits = $clog2(DelayRegs);
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 17;
  localparam int FracBits    = 16;

  localparam int MemAddrBits = ChBits + DepthLog2;
  localparam int MemDepth    = Channels << DepthLog2;

  localparam int DelayMaxInt = (DepthLog2 >= DelayBits) ? (1 << DelayBits) - 1
                                                        : (1 << DepthLog2) - 1;
  localparam logic [DelayBits-1:0] DelayMax = DelayBits'(DelayMaxInt);
  localparam logic [GainBits-1:0] UnityGain = GainBits'(1 << FracBits);

  localparam int ProdBits = GainBits + 1 + SampleBits;
  localparam int SumBits  = ProdBits + 1;
  localparam int QBits    = SumBits - FracBits;

  typedef enum logic [CfgIdxBits-1:0] {
    RegDelayCh0 = 3'd0,
    RegDelayCh1 = 3'd1,
    RegDelayCh2 = 3'd2,
    RegDelayCh3 = 3'd3,
    RegDryGain  = 3'd4,
    RegWetGain  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SrcMem  = 2'd0,
    SrcFwd  = 2'd1,
    SrcZero = 2'd2
  } src_sel_e;

  typedef struct packed {
    logic [DelayRegs-1:0][DelayBits-1:0] delay;
    logic [GainBits-1:0]                 dry_gain;
    logic [GainBits-1:0]                 wet_gain;
  } cfg_t;

  typedef struct packed {
    logic [ChBits-1:0]            channel;
    logic signed [SampleBits-1:0] sample;
    src_sel_e                     src;
  } s1_t;

endpackage

/* design/cdm_if.sv */
// valid/ready channel interfaces for sample beats in and mixed beats out
// depends on cdm_pkg

interface cdm_in_if;
  import cdm_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [ChBits-1:0]            channel;
  logic signed [SampleBits-1:0] sample_in;

  modport source (output valid, channel, sample_in, input ready);
  modport sink   (input valid, channel, sample_in, output ready);
endinterface

interface cdm_out_if;
  import cdm_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [ChBits-1:0]            channel_out;
  logic signed [SampleBits-1:0] sample_out;

  modport source (output valid, channel_out, sample_out, input ready);
  modport sink   (input valid, channel_out, sample_out, output ready);
endinterface

/* design/cdm_cfg_regs.sv */
// configuration registers: per-channel delays (clamped) and dry/wet gains
// depends on cdm_pkg

module cdm_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cdm_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [cdm_pkg::CfgDataBits-1:0] cfg_data_i,
  output cdm_pkg::cfg_t                    cfg_o
);
  import cdm_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic [DelayBits-1:0] delay_val;

  always_comb begin
    delay_val = cfg_data_i[DelayBits-1:0];
    if (delay_val > DelayMax) begin
      delay_val = DelayMax;
    end
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegDelayCh0, RegDelayCh1, RegDelayCh2, RegDelayCh3: begin
          cfg_d.delay[cfg_idx_i[DelayIdxBits-1:0]] = delay_val;
        end
        RegDryGain: begin
          cfg_d.dry_gain = cfg_data_i[GainBits-1:0];
        end
        RegWetGain: begin
          cfg_d.wet_gain = cfg_data_i[GainBits-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay    <= '0;
      cfg_q.dry_gain <= '0;
      cfg_q.wet_gain <= UnityGain;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/cdm_delay_mem.sv */
// write pointers, fill tracking and the shared delay memory (first stage)
// depends on cdm_pkg and cdm_if

module cdm_delay_mem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cdm_in_if.sink                          in_i,
  input  cdm_pkg::cfg_t                   cfg_i,
  input  logic                            adv_i,
  output logic                            s1_valid_o,
  output cdm_pkg::s1_t                    s1_o,
  output logic [cdm_pkg::SampleBits-1:0]  rdata_o
);
  import cdm_pkg::*;

  logic [Channels-1:0][DepthLog2-1:0] wp_q, wp_d;
  logic [Channels-1:0]                wrapped_q, wrapped_d;
  logic                               s1_valid_q;
  s1_t                                s1_q;
  logic [SampleBits-1:0]              rdata_q;
  logic [SampleBits-1:0]              mem_q [MemDepth];

  logic                 load;
  logic                 present;
  logic                 accept;
  logic [ChBits-1:0]    ch;
  logic [DepthLog2-1:0] w;
  logic [DepthLog2-1:0] dl;
  logic [DepthLog2-1:0] raddr;
  logic                 hist_ok;
  s1_t                  s1_d;

  assign load       = !s1_valid_q || adv_i;
  assign in_i.ready = load;
  assign ch         = in_i.channel;
  assign present    = int'(ch) < Channels;
  assign accept     = in_i.valid && load && present;
  assign w          = wp_q[ch];
  assign dl         = DepthLog2'(cfg_i.delay[ch]);
  assign raddr      = w - dl;
  assign hist_ok    = wrapped_q[ch] || (dl <= w);

  always_comb begin
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    if (accept) begin
      wp_d[ch] = w + 1'b1;
      if (w == '1) begin
        wrapped_d[ch] = 1'b1;
      end
    end
    s1_d.channel = ch;
    s1_d.sample  = in_i.sample_in;
    if (dl == '0) begin
      s1_d.src = SrcFwd;
    end else if (hist_ok) begin
      s1_d.src = SrcMem;
    end else begin
      s1_d.src = SrcZero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      wrapped_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      if (load) begin
        s1_valid_q <= in_i.valid && present;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_q <= s1_d;
    end
  end

  // read returns the old word; zero delay is forwarded from the input
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[{ch, w}] <= in_i.sample_in;
      rdata_q        <= mem_q[{ch, raddr}];
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;
  assign rdata_o    = rdata_q;

  a_zero_delay_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (dl == '0) |=> s1_valid_q && (s1_q.src == SrcFwd))
    else $error("zero delay beat not forwarded");

  a_wp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> wp_q[$past(ch)] == DepthLog2'($past(w) + 1'b1))
    else $error("write pointer did not advance");

  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (wrapped_q & $past(wrapped_q)) == $past(wrapped_q))
    else $error("wrap flag cleared");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv_i |=> s1_valid_q && $stable(s1_q))
    else $error("first stage lost a stalled beat");

endmodule

/* design/cdm_mix.sv */
// dry/wet multiply stage and round-toward-zero, saturate and output stage
// depends on cdm_pkg and cdm_if

module cdm_mix (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cdm_pkg::cfg_t                  cfg_i,
  input  logic                           s1_valid_i,
  input  cdm_pkg::s1_t                   s1_i,
  input  logic [cdm_pkg::SampleBits-1:0] rdata_i,
  output logic                           adv_o,
  cdm_out_if.source                      out_o
);
  import cdm_pkg::*;

  localparam logic signed [QBits-1:0] QMax =
    QBits'((64'd1 << (SampleBits - 1)) - 64'd1);
  localparam logic signed [QBits-1:0] QMin = ~QMax;
  localparam logic [SumBits-1:0] RoundBias = SumBits'((1 << FracBits) - 1);

  logic                         s2_valid_q;
  logic [ChBits-1:0]            s2_ch_q;
  logic signed [ProdBits-1:0]   pd_q, pw_q;
  logic signed [ProdBits-1:0]   pd_d, pw_d;
  logic signed [SampleBits-1:0] dsamp;

  logic                         out_valid_q;
  logic [ChBits-1:0]            out_ch_q;
  logic [SampleBits-1:0]        out_sample_q, out_sample_d;

  logic                         en2, en3;
  logic signed [SumBits-1:0]    sum, rnd;
  logic signed [QBits-1:0]      q;

  assign en3   = !out_valid_q || out_o.ready;
  assign en2   = !s2_valid_q || en3;
  assign adv_o = en2;

  always_comb begin
    case (s1_i.src)
      SrcFwd:  dsamp = s1_i.sample;
      SrcMem:  dsamp = $signed(rdata_i);
      SrcZero: dsamp = '0;
      default: dsamp = '0;
    endcase
    pd_d = $signed({1'b0, cfg_i.dry_gain}) * s1_i.sample;
    pw_d = $signed({1'b0, cfg_i.wet_gain}) * dsamp;
  end

  always_comb begin
    sum = SumBits'(pd_q) + SumBits'(pw_q);
    rnd = sum + $signed(sum[SumBits-1] ? RoundBias : '0);
    q   = rnd[SumBits-1:FracBits];
    if (q > QMax) begin
      out_sample_d = QMax[SampleBits-1:0];
    end else if (q < QMin) begin
      out_sample_d = QMin[SampleBits-1:0];
    end else begin
      out_sample_d = q[SampleBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en2) begin
        s2_valid_q <= s1_valid_i;
      end
      if (en3) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_ch_q <= s1_i.channel;
      pd_q    <= pd_d;
      pw_q    <= pw_d;
    end
    if (en3) begin
      out_ch_q     <= s2_ch_q;
      out_sample_q <= out_sample_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.channel_out = out_ch_q;
  assign out_o.sample_out  = out_sample_q;

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !en3 |=> s2_valid_q && $stable(pd_q) && $stable(pw_q))
    else $error("multiply stage lost a stalled beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready && s2_valid_q |=>
      s2_valid_q && out_valid_q && $stable(out_sample_q) && $stable(out_ch_q))
    else $error("pipeline accepted into a full stage");

  a_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && en3 && (pd_q == '0) && (pw_q == '0) |=> out_sample_q == '0)
    else $error("zero products gave a nonzero beat");

endmodule

/* design/compensation_delay_mix.sv */
// top level of the per-channel compensation delay with dry/wet mix
// depends on cdm_pkg, cdm_if, cdm_cfg_regs, cdm_delay_mem, cdm_mix
//
//  port        dir  handshake      payload
//  in_i        in   valid/ready    channel, sample_in
//  out_o       out  valid/ready    channel_out, sample_out
//  cfg_*_i     in   cfg_we_i only  cfg_idx_i, cfg_data_i
//
// one beat per cycle while out_o is not stalled; each beat passes the
// registered memory read, the multiply register and the output register in
// that order; ready drops only when all three stages are full
// reset clears pointers and fill flags; the memory is not swept, entries
// never written since reset read as zero through per-channel fill tracking

module compensation_delay_mix (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cdm_in_if.sink                           in_i,
  cdm_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [cdm_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [cdm_pkg::CfgDataBits-1:0] cfg_data_i
);
  import cdm_pkg::*;

  cfg_t                  cfg;
  logic                  s1_valid;
  s1_t                   s1;
  logic [SampleBits-1:0] rdata;
  logic                  adv;

  cdm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  cdm_delay_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg),
    .adv_i      (adv),
    .s1_valid_o (s1_valid),
    .s1_o       (s1),
    .rdata_o    (rdata)
  );

  cdm_mix u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .rdata_i    (rdata),
    .adv_o      (adv),
    .out_o      (out_o)
  );

endmodule
